/* rtl/core/erpp_pkg.sv */
// Shared types, widths and constant tables for the Euler rotation and
// perspective projection pipeline. No dependencies.
package erpp_pkg;

  localparam int W_PT     = 32;
  localparam int W_ANG    = 16;
  localparam int W_FOCAL  = 40;
  localparam int W_SCR    = 14;
  localparam int W_IDX    = 3;
  localparam int W_CDATA  = 40;

  // CORDIC datapath, Q2.30 with one guard bit.
  localparam int W_CXY      = 33;
  localparam int W_CZ       = 34;
  localparam int MAX_STEPS  = 24;
  localparam int TRIG_BITS  = 24;
  localparam int W_TRIG     = 26;
  localparam logic signed [W_CXY-1:0] CORDIC_GAIN = 33'sd652032874;

  // Rotation datapath.
  localparam int W_ROT  = 34;
  localparam int W_SUM  = 62;

  // Projection datapath.
  localparam int W_V        = 36;
  localparam int W_MAG      = 35;
  localparam int F_SPLIT    = 20;
  localparam int W_PP       = W_MAG + F_SPLIT;
  localparam int W_NUM      = W_MAG + W_FOCAL;
  localparam int QUOT_BITS  = 45;
  localparam int W_SCREEN   = 48;

  typedef enum logic [W_IDX-1:0] {
    REG_CAMERA_X      = 3'd0,
    REG_CAMERA_Y      = 3'd1,
    REG_CAMERA_Z      = 3'd2,
    REG_FOCAL_LENGTH  = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                    flip;
    logic signed [W_CXY-1:0] x;
    logic signed [W_CXY-1:0] y;
    logic signed [W_CZ-1:0]  z;
  } cordic_st_t;

  typedef struct packed {
    logic [W_MAG-1:0]     d;
    logic [W_MAG-1:0]     rem;
    logic [QUOT_BITS-1:0] n;
    logic [QUOT_BITS-1:0] q;
  } div_st_t;

  typedef struct packed {
    logic signed [W_PT-1:0] x;
    logic signed [W_PT-1:0] y;
    logic signed [W_PT-1:0] z;
  } point_t;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic cap_x;
    logic cap_y;
    logic clamp;
  } side_t;

  // Arctangent of 2^-i as a fraction of a quarter turn, Q2.30.
  function automatic logic [31:0] atan_lookup(input int unsigned i);
    case (i)
      0:       return 32'h20000000;
      1:       return 32'h12E4051E;
      2:       return 32'h09FB385B;
      3:       return 32'h051111D4;
      4:       return 32'h028B0D43;
      5:       return 32'h0145D7E1;
      6:       return 32'h00A2F61E;
      7:       return 32'h00517C55;
      8:       return 32'h0028BE53;
      9:       return 32'h00145F2F;
      10:      return 32'h000A2F98;
      11:      return 32'h000517CC;
      12:      return 32'h00028BE6;
      13:      return 32'h000145F3;
      14:      return 32'h0000A2FA;
      15:      return 32'h0000517D;
      16:      return 32'h000028BE;
      17:      return 32'h0000145F;
      18:      return 32'h00000A30;
      19:      return 32'h00000518;
      20:      return 32'h0000028C;
      21:      return 32'h00000146;
      22:      return 32'h000000A3;
      23:      return 32'h00000051;
      default: return 32'h00000000;
    endcase
  endfunction

  // CORDIC Q2.30 result to Q.24 with rounding, then undo the half-turn fold.
  function automatic logic signed [W_TRIG-1:0] trig_out(input logic flip,
                                                       input logic signed [W_CXY-1:0] v);
    logic signed [W_CXY:0] t;
    t = (($bits(t))'(v) + 34'sd32) >>> (30 - TRIG_BITS);
    return W_TRIG'(flip ? -t : t);
  endfunction

  // Product sum in Q.24 back to the coordinate format, add half and floor.
  function automatic logic signed [W_ROT-1:0] rnd_trig(input logic signed [W_SUM-1:0] s);
    logic signed [W_SUM-1:0] t;
    t = (s + (W_SUM'(1) <<< (TRIG_BITS - 1))) >>> TRIG_BITS;
    return W_ROT'(t);
  endfunction

endpackage

/* rtl/core/erpp_in_if.sv */
// Request channel carrying one world point and three Euler angles.
// Depends on erpp_pkg.
interface erpp_in_if import erpp_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [W_PT-1:0]  point_x;
  logic signed [W_PT-1:0]  point_y;
  logic signed [W_PT-1:0]  point_z;
  logic [W_ANG-1:0]        angle_x;
  logic [W_ANG-1:0]        angle_y;
  logic [W_ANG-1:0]        angle_z;

  modport source(output valid, point_x, point_y, point_z, angle_x, angle_y, angle_z,
                 input ready);
  modport sink(input valid, point_x, point_y, point_z, angle_x, angle_y, angle_z,
               output ready);
endinterface

/* rtl/core/erpp_out_if.sv */
// Result channel carrying one projected screen position and its flags.
// Depends on erpp_pkg.
interface erpp_out_if import erpp_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [W_PT-1:0]  screen_x;
  logic signed [W_PT-1:0]  screen_y;
  logic                    depth_clamped;
  logic                    coord_saturated;

  modport source(output valid, screen_x, screen_y, depth_clamped, coord_saturated,
                 input ready);
  modport sink(input valid, screen_x, screen_y, depth_clamped, coord_saturated,
               output ready);
endinterface

/* rtl/core/erpp_cfg_if.sv */
// Configuration write channel: register index and write data.
// Depends on erpp_pkg.
interface erpp_cfg_if import erpp_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [W_IDX-1:0]    index;
  logic [W_CDATA-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/core/erpp_cordic_cell.sv */
// One CORDIC rotation-mode micro-rotation with its pipeline register.
// Depends on erpp_pkg.
module erpp_cordic_cell import erpp_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic       clk,
  input  logic       en,
  input  cordic_st_t st_i,
  output cordic_st_t st_o
);

  localparam logic signed [W_CZ-1:0] ATAN = W_CZ'(atan_lookup(STEP));

  cordic_st_t              st_r;
  cordic_st_t              st_nxt;
  logic signed [W_CXY-1:0] x_in;
  logic signed [W_CXY-1:0] y_in;
  logic signed [W_CZ-1:0]  z_in;
  logic signed [W_CXY-1:0] xs;
  logic signed [W_CXY-1:0] ys;

  always_comb begin
    x_in = st_i.x;
    y_in = st_i.y;
    z_in = st_i.z;
    xs = x_in >>> STEP;
    ys = y_in >>> STEP;
    st_nxt.flip = st_i.flip;
    if (!z_in[W_CZ-1]) begin
      st_nxt.x = x_in - ys;
      st_nxt.y = y_in + xs;
      st_nxt.z = z_in - ATAN;
    end else begin
      st_nxt.x = x_in + ys;
      st_nxt.y = y_in - xs;
      st_nxt.z = z_in + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;

endmodule

/* rtl/core/erpp_div_cell.sv */
// One restoring-division step that settles a single quotient bit.
// Depends on erpp_pkg.
module erpp_div_cell import erpp_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic    clk,
  input  logic    en,
  input  div_st_t st_i,
  output div_st_t st_o
);

  div_st_t          st_r;
  div_st_t          st_nxt;
  logic [W_MAG:0]   rem2;

  always_comb begin
    st_nxt = st_i;
    rem2 = {st_i.rem, st_i.n[BIT]};
    if (rem2 >= {1'b0, st_i.d}) begin
      st_nxt.rem    = W_MAG'(rem2 - {1'b0, st_i.d});
      st_nxt.q[BIT] = 1'b1;
    end else begin
      st_nxt.rem = W_MAG'(rem2);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;

endmodule

/* rtl/core/euler_rotate_perspective_project_top.sv */
// Euler rotation and perspective projection pipeline, one vertex per clock.
// It accepts one request per cycle; the whole pipeline stalls only when its last stage
// holds a result and the output register is still full and not being taken.
// Reset (rst_n, synchronous, active low) empties the pipeline and output register
// and loads the camera, focal length and screen size defaults.
module euler_rotate_perspective_project_top import erpp_pkg::*;
#(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  erpp_in_if.sink    in_ch,
  erpp_out_if.source out_ch,
  erpp_cfg_if.sink   cfg_ch
);

  // Stage map: CORDIC cells, trig rounding, six rotation stages, camera/clamp,
  // two multiply stages, then one divider cell per quotient bit.
  localparam int NC = CORDIC_STEPS;
  localparam int L  = NC + 10 + QUOT_BITS;

  localparam int MIN_DEPTH_RAW = ((1 << FRAC_BITS) + 500) / 1000;
  localparam int MIN_DEPTH     = (MIN_DEPTH_RAW > 0) ? MIN_DEPTH_RAW : 1;

  localparam logic [W_FOCAL-1:0] FOCAL_RST =
    W_FOCAL'((64'd42563011 << FRAC_BITS) >> 16);
  localparam logic signed [W_PT-1:0] CAMZ_RST = W_PT'(-(64'sd4 <<< FRAC_BITS));

  localparam logic signed [W_SCREEN-1:0] S32_MAX = 48'sd2147483647;
  localparam logic signed [W_SCREEN-1:0] S32_MIN = -48'sd2147483648;

  // ---------------------------------------------------------------------
  // Configuration registers. Writes must arrive only while the pipeline
  // is idle, not enforced by the block; each stage reads them directly.
  // ---------------------------------------------------------------------
  logic signed [W_PT-1:0] cam_x_r, cam_y_r, cam_z_r;
  logic [W_FOCAL-1:0]     focal_r;
  logic [W_SCR-1:0]       scr_w_r, scr_h_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= CAMZ_RST;
      focal_r <= FOCAL_RST;
      scr_w_r <= W_SCR'(1280);
      scr_h_r <= W_SCR'(720);
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_CAMERA_X:      cam_x_r <= W_PT'(cfg_ch.data);
        REG_CAMERA_Y:      cam_y_r <= W_PT'(cfg_ch.data);
        REG_CAMERA_Z:      cam_z_r <= W_PT'(cfg_ch.data);
        REG_FOCAL_LENGTH:  focal_r <= cfg_ch.data;
        REG_SCREEN_WIDTH:  scr_w_r <= W_SCR'(cfg_ch.data);
        REG_SCREEN_HEIGHT: scr_h_r <= W_SCR'(cfg_ch.data);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Flow control. One enable moves every stage together. The output
  // register parts the two sides: a new request is taken while a result
  // waits, as long as the last stage has a bubble to fill.
  // ---------------------------------------------------------------------
  logic         en;
  logic [L-1:0] vld_r;
  logic         out_vld_r;

  assign en          = !(out_vld_r && !out_ch.ready && vld_r[L-1]);
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[L-2:0], in_ch.valid};
    end
  end

  // ---------------------------------------------------------------------
  // CORDIC chains, one per angle. Angles in the second and third quadrant
  // are folded by a half turn here and the sign is restored at the end.
  // ---------------------------------------------------------------------
  cordic_st_t ca_st [3][NC+1];
  point_t     pt_r  [NC];
  logic [W_ANG-1:0] ang [3];

  assign ang[0] = in_ch.angle_x;
  assign ang[1] = in_ch.angle_y;
  assign ang[2] = in_ch.angle_z;

  genvar a, k;
  generate
    for (a = 0; a < 3; a++) begin : g_axis
      assign ca_st[a][0].flip = ang[a][W_ANG-1] ^ ang[a][W_ANG-2];
      assign ca_st[a][0].x    = CORDIC_GAIN;
      assign ca_st[a][0].y    = '0;
      assign ca_st[a][0].z    = W_CZ'($signed({ang[a][W_ANG-1] ^ ca_st[a][0].flip,
                                               ang[a][W_ANG-2:0], 16'h0000}));
      for (k = 0; k < NC; k++) begin : g_cell
        erpp_cordic_cell #(.STEP(k)) u_cell (
          .clk  (clk),
          .en   (en),
          .st_i (ca_st[a][k]),
          .st_o (ca_st[a][k+1])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      pt_r[0] <= '{x: in_ch.point_x, y: in_ch.point_y, z: in_ch.point_z};
      for (int i = 1; i < NC; i++) begin
        pt_r[i] <= pt_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Trig rounding to Q.24, then the three rotations. Each rotation is one
  // multiply stage and one add-and-round stage.
  // ---------------------------------------------------------------------
  logic signed [W_TRIG-1:0] cx_r, sx_r, cy_r, sy_r, cz_r, sz_r;
  point_t                   t_pt_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r   <= trig_out(ca_st[0][NC].flip, ca_st[0][NC].x);
      sx_r   <= trig_out(ca_st[0][NC].flip, ca_st[0][NC].y);
      cy_r   <= trig_out(ca_st[1][NC].flip, ca_st[1][NC].x);
      sy_r   <= trig_out(ca_st[1][NC].flip, ca_st[1][NC].y);
      cz_r   <= trig_out(ca_st[2][NC].flip, ca_st[2][NC].x);
      sz_r   <= trig_out(ca_st[2][NC].flip, ca_st[2][NC].y);
      t_pt_r <= pt_r[NC-1];
    end
  end

  // Rotation about X.
  logic signed [W_PT+W_TRIG-1:0] r1_ycx_r, r1_zsx_r, r1_ysx_r, r1_zcx_r;
  logic signed [W_PT-1:0]        r1_x_r;
  logic signed [W_TRIG-1:0]      r1_cy_r, r1_sy_r, r1_cz_r, r1_sz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r1_ycx_r <= t_pt_r.y * cx_r;
      r1_zsx_r <= t_pt_r.z * sx_r;
      r1_ysx_r <= t_pt_r.y * sx_r;
      r1_zcx_r <= t_pt_r.z * cx_r;
      r1_x_r   <= t_pt_r.x;
      r1_cy_r  <= cy_r;
      r1_sy_r  <= sy_r;
      r1_cz_r  <= cz_r;
      r1_sz_r  <= sz_r;
    end
  end

  logic signed [W_ROT-1:0]  r2_x1_r, r2_y1_r, r2_z1_r;
  logic signed [W_TRIG-1:0] r2_cy_r, r2_sy_r, r2_cz_r, r2_sz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r2_x1_r <= W_ROT'(r1_x_r);
      r2_y1_r <= rnd_trig(W_SUM'(r1_ycx_r) - W_SUM'(r1_zsx_r));
      r2_z1_r <= rnd_trig(W_SUM'(r1_ysx_r) + W_SUM'(r1_zcx_r));
      r2_cy_r <= r1_cy_r;
      r2_sy_r <= r1_sy_r;
      r2_cz_r <= r1_cz_r;
      r2_sz_r <= r1_sz_r;
    end
  end

  // Rotation about Y.
  logic signed [W_ROT+W_TRIG-1:0] r3_xcy_r, r3_zsy_r, r3_zcy_r, r3_xsy_r;
  logic signed [W_ROT-1:0]        r3_y1_r;
  logic signed [W_TRIG-1:0]       r3_cz_r, r3_sz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r3_xcy_r <= r2_x1_r * r2_cy_r;
      r3_zsy_r <= r2_z1_r * r2_sy_r;
      r3_zcy_r <= r2_z1_r * r2_cy_r;
      r3_xsy_r <= r2_x1_r * r2_sy_r;
      r3_y1_r  <= r2_y1_r;
      r3_cz_r  <= r2_cz_r;
      r3_sz_r  <= r2_sz_r;
    end
  end

  logic signed [W_ROT-1:0]  r4_x2_r, r4_z2_r, r4_y1_r;
  logic signed [W_TRIG-1:0] r4_cz_r, r4_sz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r4_x2_r <= rnd_trig(W_SUM'(r3_xcy_r) + W_SUM'(r3_zsy_r));
      r4_z2_r <= rnd_trig(W_SUM'(r3_zcy_r) - W_SUM'(r3_xsy_r));
      r4_y1_r <= r3_y1_r;
      r4_cz_r <= r3_cz_r;
      r4_sz_r <= r3_sz_r;
    end
  end

  // Rotation about Z.
  logic signed [W_ROT+W_TRIG-1:0] r5_xcz_r, r5_ysz_r, r5_xsz_r, r5_ycz_r;
  logic signed [W_ROT-1:0]        r5_z2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r5_xcz_r <= r4_x2_r * r4_cz_r;
      r5_ysz_r <= r4_y1_r * r4_sz_r;
      r5_xsz_r <= r4_x2_r * r4_sz_r;
      r5_ycz_r <= r4_y1_r * r4_cz_r;
      r5_z2_r  <= r4_z2_r;
    end
  end

  logic signed [W_ROT-1:0] r6_x3_r, r6_y3_r, r6_z2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r6_x3_r <= rnd_trig(W_SUM'(r5_xcz_r) - W_SUM'(r5_ysz_r));
      r6_y3_r <= rnd_trig(W_SUM'(r5_xsz_r) + W_SUM'(r5_ycz_r));
      r6_z2_r <= r5_z2_r;
    end
  end

  // ---------------------------------------------------------------------
  // Camera offset and minimum depth. The coordinates are split into sign
  // and magnitude for the unsigned divider.
  // ---------------------------------------------------------------------
  logic signed [W_V-1:0] vx, vy, vz;
  logic [W_MAG-1:0]      v_magx_r, v_magy_r, v_d_r;
  logic                  v_negx_r, v_negy_r, v_clamp_r;

  always_comb begin
    vx = W_V'(r6_x3_r) - W_V'(cam_x_r);
    vy = W_V'(r6_y3_r) - W_V'(cam_y_r);
    vz = W_V'(r6_z2_r) - W_V'(cam_z_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_negx_r <= vx[W_V-1];
      v_negy_r <= vy[W_V-1];
      v_magx_r <= W_MAG'(vx[W_V-1] ? -vx : vx);
      v_magy_r <= W_MAG'(vy[W_V-1] ? -vy : vy);
      if (vz < W_V'(MIN_DEPTH)) begin
        v_d_r     <= W_MAG'(MIN_DEPTH);
        v_clamp_r <= 1'b1;
      end else begin
        v_d_r     <= W_MAG'(vz);
        v_clamp_r <= 1'b0;
      end
    end
  end

  // The magnitude times focal length product is split over the focal
  // length into two partial products, summed in the next stage.
  logic [W_PP-1:0]  m1_xlo_r, m1_xhi_r, m1_ylo_r, m1_yhi_r;
  logic [W_MAG-1:0] m1_d_r;
  logic             m1_negx_r, m1_negy_r, m1_clamp_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_xlo_r   <= v_magx_r * focal_r[F_SPLIT-1:0];
      m1_xhi_r   <= v_magx_r * focal_r[W_FOCAL-1:F_SPLIT];
      m1_ylo_r   <= v_magy_r * focal_r[F_SPLIT-1:0];
      m1_yhi_r   <= v_magy_r * focal_r[W_FOCAL-1:F_SPLIT];
      m1_d_r     <= v_d_r;
      m1_negx_r  <= v_negx_r;
      m1_negy_r  <= v_negy_r;
      m1_clamp_r <= v_clamp_r;
    end
  end

  // Full dividend, and the overflow test: a quotient of 2^45 or more is
  // held at 2^45, which is the case when the bits from 45 upward reach the depth.
  logic [W_NUM-1:0] num_x, num_y;
  div_st_t          dvx_st [QUOT_BITS+1];
  div_st_t          dvy_st [QUOT_BITS+1];
  div_st_t          m2_x_r, m2_y_r;
  side_t            sd_r   [QUOT_BITS+1];

  always_comb begin
    num_x = W_NUM'(m1_xlo_r) + (W_NUM'(m1_xhi_r) << F_SPLIT);
    num_y = W_NUM'(m1_ylo_r) + (W_NUM'(m1_yhi_r) << F_SPLIT);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_x_r <= '{d: m1_d_r, rem: W_MAG'(num_x[W_NUM-1:QUOT_BITS]),
                 n: num_x[QUOT_BITS-1:0], q: '0};
      m2_y_r <= '{d: m1_d_r, rem: W_MAG'(num_y[W_NUM-1:QUOT_BITS]),
                 n: num_y[QUOT_BITS-1:0], q: '0};
      sd_r[0] <= '{neg_x: m1_negx_r, neg_y: m1_negy_r,
                   cap_x: (W_MAG'(num_x[W_NUM-1:QUOT_BITS]) >= m1_d_r),
                   cap_y: (W_MAG'(num_y[W_NUM-1:QUOT_BITS]) >= m1_d_r),
                   clamp: m1_clamp_r};
      for (int i = 1; i <= QUOT_BITS; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
    end
  end

  assign dvx_st[0] = m2_x_r;
  assign dvy_st[0] = m2_y_r;

  // Divider chain: one cell per quotient bit, most significant first.
  genvar j;
  generate
    for (j = 0; j < QUOT_BITS; j++) begin : g_div
      erpp_div_cell #(.BIT(QUOT_BITS - 1 - j)) u_div_x (
        .clk  (clk),
        .en   (en),
        .st_i (dvx_st[j]),
        .st_o (dvx_st[j+1])
      );
      erpp_div_cell #(.BIT(QUOT_BITS - 1 - j)) u_div_y (
        .clk  (clk),
        .en   (en),
        .st_i (dvy_st[j]),
        .st_o (dvy_st[j+1])
      );
    end
  endgenerate

  // ---------------------------------------------------------------------
  // Centering, y flip and saturation into the output register.
  // ---------------------------------------------------------------------
  side_t                    sd_last;
  logic signed [W_SCREEN-1:0] qx, qy, cen_x, cen_y, sx, sy;
  logic                     sat_x, sat_y;
  logic signed [W_PT-1:0]   scr_x_r, scr_y_r;
  logic                     clamp_out_r, sat_out_r;

  always_comb begin
    sd_last = sd_r[QUOT_BITS];
    qx = sd_last.cap_x ? (W_SCREEN'(1) <<< QUOT_BITS)
                       : $signed(W_SCREEN'(dvx_st[QUOT_BITS].q));
    qy = sd_last.cap_y ? (W_SCREEN'(1) <<< QUOT_BITS)
                       : $signed(W_SCREEN'(dvy_st[QUOT_BITS].q));
    if (sd_last.neg_x) begin
      qx = -qx;
    end
    if (sd_last.neg_y) begin
      qy = -qy;
    end
    cen_x = $signed(W_SCREEN'(scr_w_r) << (FRAC_BITS - 1));
    cen_y = $signed(W_SCREEN'(scr_h_r) << (FRAC_BITS - 1));
    sx = cen_x + qx;
    sy = cen_y - qy;
    sat_x = (sx > S32_MAX) || (sx < S32_MIN);
    sat_y = (sy > S32_MAX) || (sy < S32_MIN);
    if (sx > S32_MAX) begin
      sx = S32_MAX;
    end else if (sx < S32_MIN) begin
      sx = S32_MIN;
    end
    if (sy > S32_MAX) begin
      sy = S32_MAX;
    end else if (sy < S32_MIN) begin
      sy = S32_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en && vld_r[L-1]) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_r[L-1]) begin
      scr_x_r     <= W_PT'(sx);
      scr_y_r     <= W_PT'(sy);
      clamp_out_r <= sd_last.clamp;
      sat_out_r   <= sat_x || sat_y;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.screen_x        = scr_x_r;
  assign out_ch.screen_y        = scr_y_r;
  assign out_ch.depth_clamped   = clamp_out_r;
  assign out_ch.coord_saturated = sat_out_r;

endmodule

/* rtl/core/erpp_checker.sv */
// Port-level checks on the projection pipeline, bound to the top level.
// Depends on erpp_pkg and euler_rotate_perspective_project_top.
module erpp_checker import erpp_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic signed [W_PT-1:0] screen_x,
  input logic signed [W_PT-1:0] screen_y,
  input logic                   coord_saturated
);

  localparam logic signed [W_PT-1:0] P_MAX = 32'sh7FFFFFFF;
  localparam logic signed [W_PT-1:0] P_MIN = 32'sh80000000;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(screen_x) && $stable(screen_y))
    else $error("stalled result changed");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && coord_saturated |-> (screen_x == P_MAX) || (screen_x == P_MIN) ||
                                     (screen_y == P_MAX) || (screen_y == P_MIN))
    else $error("saturation flag without a coordinate at its limit");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind euler_rotate_perspective_project_top erpp_checker u_erpp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .screen_x        (out_ch.screen_x),
  .screen_y        (out_ch.screen_y),
  .coord_saturated (out_ch.coord_saturated)
);
